### rtl/mrpase_pkg.sv
// Package: types, codes, applicant transition table and transmit actions of the MRP attribute state engine.
package mrpase_pkg;

  localparam int ATTR_COUNT = 256;
  localparam int IDX_W      = $clog2(ATTR_COUNT);
  localparam int EV_LISTED  = 15;

  localparam logic [4:0] KIND_RNEW    = 5'd3;
  localparam logic [4:0] KIND_RJOININ = 5'd4;
  localparam logic [4:0] KIND_RJOINMT = 5'd6;
  localparam logic [4:0] KIND_RLV     = 5'd8;
  localparam logic [4:0] KIND_RLA     = 5'd9;
  localparam logic [4:0] KIND_REDECL  = 5'd10;
  localparam logic [4:0] KIND_TX      = 5'd12;
  localparam logic [4:0] KIND_TXLA    = 5'd13;
  localparam logic [4:0] KIND_FLUSH   = 5'd15;
  localparam logic [4:0] KIND_LVTIMER = 5'd16;

  typedef enum logic [3:0] {
    AS_VO = 4'd0, AS_VP = 4'd1, AS_VN = 4'd2, AS_AN = 4'd3,
    AS_AA = 4'd4, AS_QA = 4'd5, AS_LA = 4'd6, AS_AO = 4'd7,
    AS_QO = 4'd8, AS_AP = 4'd9, AS_QP = 4'd10, AS_LO = 4'd11
  } app_e;

  typedef enum logic [1:0] {
    RS_IN = 2'd0, RS_LV = 2'd1, RS_MT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0, ACT_SJ = 3'd1, ACT_SN = 3'd2, ACT_SL = 3'd3, ACT_S = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    MSG_NONE = 3'd0, MSG_NEW = 3'd1, MSG_JOININ = 3'd2, MSG_JOINMT = 3'd3,
    MSG_LV = 3'd4, MSG_IN = 3'd5, MSG_MT = 3'd6
  } msg_e;

  typedef enum logic [1:0] {
    LTC_NONE = 2'd0, LTC_START = 2'd1, LTC_STOP = 2'd2
  } ltc_e;

  typedef enum logic [2:0] {
    ROP_NONE = 3'd0, ROP_RNEW = 3'd1, ROP_RJOIN = 3'd2, ROP_RLEAVE = 3'd3,
    ROP_FLUSH = 3'd4, ROP_LTIMER = 3'd5
  } reg_op_e;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    reg_op_e          reg_op;
    logic             app_ok;
    logic [3:0]       app_ev;
    logic             pdu_full;
  } item_t;

  typedef struct packed {
    app_e applicant_now;
    reg_e registrar_now;
    logic join_ind;
    logic new_flag;
    logic leave_ind;
    ltc_e ltc;
    logic tx_req;
    msg_e msg;
    logic appended;
  } res_t;

  // applicant next state, rows by current state, columns by event
  localparam app_e APP_NXT [12][EV_LISTED] = '{
    '{AS_VN, AS_VP, AS_VO, AS_VO, AS_AO, AS_VO, AS_VO, AS_VO,
      AS_LO, AS_LO, AS_LO, AS_VO, AS_VO, AS_LO, AS_LO},
    '{AS_VN, AS_VP, AS_VO, AS_VP, AS_AP, AS_VP, AS_VP, AS_VP,
      AS_VP, AS_VP, AS_VP, AS_VP, AS_AA, AS_AA, AS_VP},
    '{AS_VN, AS_VN, AS_LA, AS_VN, AS_VN, AS_VN, AS_VN, AS_VN,
      AS_VN, AS_VN, AS_VN, AS_VN, AS_AN, AS_AN, AS_VN},
    '{AS_AN, AS_AN, AS_LA, AS_AN, AS_AN, AS_AN, AS_AN, AS_AN,
      AS_VN, AS_VN, AS_VN, AS_AN, AS_QA, AS_QA, AS_VN},
    '{AS_VN, AS_AA, AS_LA, AS_AA, AS_QA, AS_QA, AS_AA, AS_AA,
      AS_VP, AS_VP, AS_VP, AS_AA, AS_QA, AS_QA, AS_VP},
    '{AS_VN, AS_QA, AS_LA, AS_QA, AS_QA, AS_QA, AS_AA, AS_AA,
      AS_VP, AS_VP, AS_VP, AS_AA, AS_QA, AS_QA, AS_VP},
    '{AS_VN, AS_AA, AS_LA, AS_LA, AS_LA, AS_LA, AS_LA, AS_LA,
      AS_LA, AS_LA, AS_LA, AS_LA, AS_VO, AS_LO, AS_LO},
    '{AS_VN, AS_AP, AS_AO, AS_AO, AS_QO, AS_AO, AS_AO, AS_LO,
      AS_LO, AS_LO, AS_LO, AS_AO, AS_AO, AS_LO, AS_LO},
    '{AS_VN, AS_QP, AS_QO, AS_QO, AS_QO, AS_QO, AS_AO, AS_AO,
      AS_LO, AS_LO, AS_LO, AS_QO, AS_QO, AS_LO, AS_LO},
    '{AS_VN, AS_AP, AS_AO, AS_AP, AS_QP, AS_AP, AS_AP, AS_AP,
      AS_VP, AS_VP, AS_VP, AS_AP, AS_QA, AS_QA, AS_VP},
    '{AS_VN, AS_QP, AS_QO, AS_QP, AS_QP, AS_QP, AS_AP, AS_AP,
      AS_VP, AS_VP, AS_VP, AS_AP, AS_QP, AS_QA, AS_VP},
    '{AS_VN, AS_VP, AS_LO, AS_LO, AS_LO, AS_LO, AS_VO, AS_VO,
      AS_LO, AS_LO, AS_LO, AS_LO, AS_VO, AS_LO, AS_LO}
  };

  // transmit action; only tx and txLA carry one
  function automatic act_e app_act(app_e st, logic [3:0] ev);
    logic is_tx;
    logic is_txla;
    act_e act;
    is_tx   = (ev == KIND_TX[3:0]);
    is_txla = (ev == KIND_TXLA[3:0]);
    act     = ACT_NONE;
    case (st) inside
      AS_VP: begin
        if (is_tx) act = ACT_SJ;
        else if (is_txla) act = ACT_S;
      end
      AS_VN, AS_AN: begin
        if (is_tx || is_txla) act = ACT_SN;
      end
      AS_AA, AS_AP: begin
        if (is_tx || is_txla) act = ACT_SJ;
      end
      AS_QA, AS_QP: begin
        if (is_txla) act = ACT_SJ;
      end
      AS_LA: begin
        if (is_tx) act = ACT_SL;
      end
      AS_LO: begin
        if (is_tx) act = ACT_S;
      end
      default: act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

### rtl/mrp_attribute_state_engine_top.sv
// Top level of the MRP attribute state engine.
// Input channel: drive attr_index_i, kind_i, pdu_full_i with push; a beat is
// taken on a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on the result
// ports; it is taken on a clock edge where pop is high. One result per event,
// in event order.
// Path: an event passes through the decode queue, the RAM read register and the result queue.
// The back end takes a new event only after the read and write-back of the
// previous one in the per-attribute state RAM (256 entries of applicant and registrar state).
// A two-entry queue sits between decode and update, and a two-entry result
// queue sits at the output.
// Reset: all attributes read as applicant VO, registrar MT at once (per-entry
// valid bits), no clearing pass.
// When pop stays low, the result queue fills, the update stage halts, the
// decode queue fills and full rises; nothing is lost.
module mrp_attribute_state_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] attr_index_i,
  input  logic [4:0] kind_i,
  input  logic       pdu_full_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] applicant_now_o,
  output logic [1:0] registrar_now_o,
  output logic       join_indication_o,
  output logic       new_flag_o,
  output logic       leave_indication_o,
  output logic [1:0] leave_timer_cmd_o,
  output logic       tx_request_o,
  output logic [2:0] message_o,
  output logic       appended_o
);
  import mrpase_pkg::*;

  item_t fq_item;
  logic  fq_valid;
  logic  fq_take;
  res_t  head;

  mrpase_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .attr_index_i (attr_index_i),
    .kind_i       (kind_i),
    .pdu_full_i   (pdu_full_i),
    .valid_o      (fq_valid),
    .item_o       (fq_item),
    .take_i       (fq_take)
  );

  mrpase_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_valid_i (fq_valid),
    .fq_item_i  (fq_item),
    .fq_take_o  (fq_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .head_o     (head)
  );

  assign applicant_now_o    = head.applicant_now;
  assign registrar_now_o    = head.registrar_now;
  assign join_indication_o  = head.join_ind;
  assign new_flag_o         = head.new_flag;
  assign leave_indication_o = head.leave_ind;
  assign leave_timer_cmd_o  = head.ltc;
  assign tx_request_o       = head.tx_req;
  assign message_o          = head.msg;
  assign appended_o         = head.appended;

endmodule

### rtl/mrpase_front.sv
// Front end: accepts events, decodes them and queues them for the back end.
module mrpase_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            attr_index_i,
  input  logic [4:0]            kind_i,
  input  logic                  pdu_full_i,
  output logic                  valid_o,
  output mrpase_pkg::item_t     item_o,
  input  logic                  take_i
);
  import mrpase_pkg::*;

  item_t       item_q [2];
  item_t       dec;
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  always_comb begin
    dec          = '0;
    dec.idx      = IDX_W'(attr_index_i);
    dec.app_ok   = (kind_i < 5'(EV_LISTED));
    dec.app_ev   = kind_i[3:0];
    dec.pdu_full = pdu_full_i;
    unique case (kind_i) inside
      KIND_RNEW:                                    dec.reg_op = ROP_RNEW;
      KIND_RJOININ, KIND_RJOINMT:                   dec.reg_op = ROP_RJOIN;
      KIND_RLV, KIND_RLA, KIND_REDECL, KIND_TXLA:   dec.reg_op = ROP_RLEAVE;
      KIND_FLUSH:                                   dec.reg_op = ROP_FLUSH;
      KIND_LVTIMER:                                 dec.reg_op = ROP_LTIMER;
      default:                                      dec.reg_op = ROP_NONE;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = item_q[rp_q];
  assign wr      = push_i && !full_o;
  assign rd      = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) item_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### rtl/mrpase_back.sv
// Back end: per-attribute state RAM, registrar/applicant update and result queue.
module mrpase_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fq_valid_i,
  input  mrpase_pkg::item_t     fq_item_i,
  output logic                  fq_take_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output mrpase_pkg::res_t      head_o
);
  import mrpase_pkg::*;

  typedef enum logic [1:0] {
    S_RD = 2'b01,
    S_EX = 2'b10
  } back_state_e;

  back_state_e            state_q, state_d;
  logic [5:0]             state_mem_q [ATTR_COUNT];
  logic [ATTR_COUNT-1:0]  vld_q;
  logic [5:0]             rdata_q;
  logic                   rvld_q;
  item_t                  cur_q;
  res_t                   res_q [2];
  res_t                   res_d;
  logic                   wp_q, rp_q;
  logic [1:0]             cnt_q;
  logic                   res_push, res_pop;

  assign fq_take_o = (state_q == S_RD) && fq_valid_i && (cnt_q != 2'd2);
  assign res_push  = (state_q == S_EX);
  assign res_pop   = pop_i && (cnt_q != 2'd0);
  assign empty_o   = (cnt_q == 2'd0);
  assign head_o    = res_q[rp_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RD:    if (fq_take_o) state_d = S_EX;
      S_EX:    state_d = S_RD;
      default: state_d = S_RD;
    endcase
  end

  always_comb begin
    reg_e  rg;
    app_e  ap;
    act_e  act;
    app_e  nxt;
    logic  reg_in;
    rg = RS_MT;
    ap = AS_VO;
    if (rvld_q) begin
      if (rdata_q[1:0] <= RS_MT) rg = reg_e'(rdata_q[1:0]);
      if (rdata_q[5:2] <= AS_LO) ap = app_e'(rdata_q[5:2]);
    end
    res_d = '0;
    case (cur_q.reg_op)
      ROP_RNEW: begin
        if (rg == RS_LV) res_d.ltc = LTC_STOP;
        res_d.join_ind = 1'b1;
        res_d.new_flag = 1'b1;
        rg = RS_IN;
      end
      ROP_RJOIN: begin
        if (rg == RS_MT) res_d.join_ind = 1'b1;
        else if (rg == RS_LV) res_d.ltc = LTC_STOP;
        rg = RS_IN;
      end
      ROP_RLEAVE: begin
        if (rg == RS_IN) begin
          res_d.ltc = LTC_START;
          rg = RS_LV;
        end
      end
      ROP_FLUSH: begin
        if (rg == RS_LV) res_d.leave_ind = 1'b1;
        rg = RS_MT;
      end
      ROP_LTIMER: begin
        if (rg == RS_LV) begin
          res_d.leave_ind = 1'b1;
          rg = RS_MT;
        end
      end
      default: ;
    endcase
    reg_in = (rg == RS_IN);
    act    = app_act(ap, cur_q.app_ev);
    nxt    = APP_NXT[ap][cur_q.app_ev];
    if (cur_q.app_ok) begin
      if (act != ACT_NONE) begin
        res_d.tx_req   = 1'b1;
        res_d.appended = !cur_q.pdu_full;
        case (act)
          ACT_SJ:  res_d.msg = reg_in ? MSG_JOININ : MSG_JOINMT;
          ACT_SN:  res_d.msg = MSG_NEW;
          ACT_SL:  res_d.msg = MSG_LV;
          default: res_d.msg = reg_in ? MSG_IN : MSG_MT;
        endcase
        if (!cur_q.pdu_full) ap = nxt;
      end else begin
        ap = nxt;
      end
    end
    res_d.applicant_now = ap;
    res_d.registrar_now = rg;
  end

  always_ff @(posedge clk_i) begin
    if (fq_take_o) begin
      rdata_q <= state_mem_q[fq_item_i.idx];
      cur_q   <= fq_item_i;
    end
    if (res_push) begin
      state_mem_q[cur_q.idx] <= {res_d.applicant_now, res_d.registrar_now};
      res_q[wp_q]            <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RD;
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (fq_take_o) rvld_q <= vld_q[fq_item_i.idx];
      if (res_push) begin
        vld_q[cur_q.idx] <= 1'b1;
        wp_q             <= ~wp_q;
      end
      if (res_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (cnt_q != 2'd2)) else $error("result beat pushed into full queue");

  a_take_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_take_o |=> (state_q == S_EX)) else $error("no update after RAM read");

  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EX) |=> (state_q == S_RD && !res_push))
    else $error("update ran twice for one beat");

  a_msg_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res_d.tx_req) |-> (res_d.msg == MSG_NONE && !res_d.appended))
    else $error("message without transmit request");

endmodule
